// ===== hw/rtl/sha256_message_hasher_core_assert.svh =====
// ----------------------------------------------------------------------------
// sha256 message hasher assertion macros
// implication checks on the core clock, held off during reset
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SHA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sha256 core check failed");

// next-cycle implication
`define SHA_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sha256 core check failed");

`else

`define SHA_ASSERT_IMP(label, ante, cons)
`define SHA_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/sha_mh_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_mh_pkg
// sha-256 constants, sequencer codes and round helper functions
// ----------------------------------------------------------------------------
`default_nettype none

package sha_mh_pkg;

   typedef logic [31:0] word_type;

   // sequencer state codes
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_FOLD  = 3'd3;
   localparam logic [2:0] ST_SEND  = 3'd4;

   localparam logic [5:0] LAST_POS   = 6'd63;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [1:0] WORD_END   = 2'd3;
   localparam logic [2:0] LAST_IDX   = 3'd7;
   localparam logic [7:0] PAD_MARK   = 8'h80;

   function automatic word_type round_const(input logic [5:0] t);
      word_type k;
      case (t)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic word_type init_hash(input logic [2:0] i);
      word_type h;
      case (i)
         3'd0: h = 32'h6a09e667;
         3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372;
         3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f;
         3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab;
         3'd7: h = 32'h5be0cd19;
         default: h = 32'h0;
      endcase
      return h;
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sha256_message_hasher_core.sv =====
// ----------------------------------------------------------------------------
// sha256_message_hasher_core
// byte-serial sha-256 hasher: packs bytes, pads, compresses, emits 8 words
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   req     | in        | req_valid/req_stall | data_byte, byte_present, end_of_message
//   rsp     | out       | rsp_valid/rsp_stall | digest_word, word_index, last_word
//
// a request that neither completes a block nor ends the message leaves the core idle
// a request that completes a 64-byte block runs the compression rounds and then
//   the fold, all on the single shared round unit
// end of message: padding bytes, one or two block compressions, then the 8 digest
//   words, each held for as long as rsp_stall is high
// reset is synchronous; the core comes out ready with the initial hash loaded
// req_stall is high whenever the sequencer is not idle
//
`default_nettype none
`include "sha256_message_hasher_core_assert.svh"

module sha256_message_hasher_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_end_of_message,
   // response channel
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_digest_word,
   output      logic [2:0]  rsp_word_index,
   output      logic        rsp_last_word
);

   import sha_mh_pkg::*;

   // sequencer and counters
   logic [2:0]  state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;          // offset inside the current block
   logic [60:0] total_ff, total_in;      // message bytes, wraps mod 2^61
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;          // digest word being sent
   logic        ret_pad_ff, ret_pad_in;  // go back to padding after the fold
   logic        done_ff, done_in;        // the block being compressed holds the length field
   logic        pad_first_ff, pad_first_in;
   logic        len_ff, len_in;          // length bytes are being placed

   // datapath
   word_type    hash_ff [8];
   word_type    hash_in [8];
   word_type    vars_ff [8];
   word_type    vars_in [8];
   word_type    win_ff  [16];            // rolling schedule, win_ff[0] is w[t]
   word_type    win_in  [16];
   logic [23:0] partial_ff, partial_in;  // earlier bytes of the word in flight

   // shared absorb / shift control
   logic        absorb_en;
   logic [7:0]  absorb_byte;
   logic        shift_en;
   word_type    shift_word;

   // padding byte selection
   logic [63:0] bit_len;
   logic [7:0]  len_byte;
   logic        len_sel;
   logic [7:0]  pad_byte;

   // round unit
   word_type    sched_new;
   word_type    t1;
   word_type    t2;
   word_type    ch;
   word_type    maj;

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_SEND);
   assign rsp_digest_word = hash_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == LAST_IDX);

   // length field is the bit count, big-endian, in block bytes 56..63
   assign bit_len = {total_ff, 3'b000};

   always_comb begin
      case (pos_ff[2:0])
         3'd0:    len_byte = bit_len[63:56];
         3'd1:    len_byte = bit_len[55:48];
         3'd2:    len_byte = bit_len[47:40];
         3'd3:    len_byte = bit_len[39:32];
         3'd4:    len_byte = bit_len[31:24];
         3'd5:    len_byte = bit_len[23:16];
         3'd6:    len_byte = bit_len[15:8];
         3'd7:    len_byte = bit_len[7:0];
         default: len_byte = 8'h00;
      endcase
   end

   // 0x80 first, zeros until offset 56 comes up after it, then length bytes
   assign len_sel  = !pad_first_ff && ((pos_ff == LEN_POS) || len_ff);
   assign pad_byte = pad_first_ff ? PAD_MARK : (len_sel ? len_byte : 8'h00);

   // one compression round: next schedule word and the new a..h
   assign sched_new = win_ff[0] + small_sigma0(win_ff[1]) + win_ff[9]
                    + small_sigma1(win_ff[14]);
   assign ch  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign maj = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
              ^ (vars_ff[1] & vars_ff[2]);
   assign t1  = vars_ff[7] + big_sigma1(vars_ff[4]) + ch + round_const(round_ff)
              + win_ff[0];
   assign t2  = big_sigma0(vars_ff[0]) + maj;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      round_in     = round_ff;
      idx_in       = idx_ff;
      ret_pad_in   = ret_pad_ff;
      done_in      = done_ff;
      pad_first_in = pad_first_ff;
      len_in       = len_ff;
      partial_in   = partial_ff;
      hash_in      = hash_ff;
      vars_in      = vars_ff;
      win_in       = win_ff;
      absorb_en    = 1'b0;
      absorb_byte  = 8'h00;
      shift_en     = 1'b0;
      shift_word   = sched_new;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_byte_present) begin
                  absorb_en   = 1'b1;
                  absorb_byte = req_data_byte;
                  total_in    = total_ff + 61'd1;
               end
               if (req_end_of_message) begin
                  pad_first_in = 1'b1;
                  len_in       = 1'b0;
               end
               if (req_byte_present && (pos_ff == LAST_POS)) begin
                  state_in   = ST_ROUND;
                  ret_pad_in = req_end_of_message;
                  done_in    = 1'b0;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            absorb_en    = 1'b1;
            absorb_byte  = pad_byte;
            pad_first_in = 1'b0;
            len_in       = len_sel;
            if (pos_ff == LAST_POS) begin
               state_in   = ST_ROUND;
               ret_pad_in = 1'b1;
               done_in    = len_sel;
            end
         end
         ST_ROUND: begin
            shift_en   = 1'b1;
            vars_in[7] = vars_ff[6];
            vars_in[6] = vars_ff[5];
            vars_in[5] = vars_ff[4];
            vars_in[4] = vars_ff[3] + t1;
            vars_in[3] = vars_ff[2];
            vars_in[2] = vars_ff[1];
            vars_in[1] = vars_ff[0];
            vars_in[0] = t1 + t2;
            round_in   = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + vars_ff[i];
            end
            idx_in = 3'd0;
            if (done_ff) begin
               state_in = ST_SEND;
            end else if (ret_pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LAST_IDX) begin
                  for (int i = 0; i < 8; i++) begin
                     hash_in[i] = init_hash(3'(i));
                  end
                  total_in = '0;
                  done_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // byte packing, shared by message and padding bytes
      if (absorb_en) begin
         partial_in = {partial_ff[15:0], absorb_byte};
         pos_in     = pos_ff + 6'd1;
         if (pos_ff[1:0] == WORD_END) begin
            shift_en   = 1'b1;
            shift_word = {partial_ff, absorb_byte};
         end
         if (pos_ff == LAST_POS) begin
            vars_in  = hash_ff;
            round_in = 6'd0;
         end
      end

      if (shift_en) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = shift_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         total_ff     <= '0;
         round_ff     <= '0;
         idx_ff       <= '0;
         ret_pad_ff   <= 1'b0;
         done_ff      <= 1'b0;
         pad_first_ff <= 1'b0;
         len_ff       <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= init_hash(3'(i));
         end
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         round_ff     <= round_in;
         idx_ff       <= idx_in;
         ret_pad_ff   <= ret_pad_in;
         done_ff      <= done_in;
         pad_first_ff <= pad_first_in;
         len_ff       <= len_in;
         hash_ff      <= hash_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      vars_ff    <= vars_in;
      win_ff     <= win_in;
      partial_ff <= partial_in;
   end

   // no request is taken while digest words are going out
   `SHA_ASSERT_IMP(a_send_blocks_req, rsp_valid, req_stall)
   // the last round always hands over to the fold
   `SHA_ASSERT_NXT(a_round_to_fold, (state_ff == ST_ROUND) && (round_ff == LAST_ROUND),
                   state_ff == ST_FOLD)
   // a request that fills a block starts compression at round zero
   `SHA_ASSERT_NXT(a_block_starts_rounds,
                   req_valid && !req_stall && req_byte_present && (pos_ff == LAST_POS),
                   (state_ff == ST_ROUND) && (round_ff == 6'd0))
   // the final digest word leaves the core idle with a fresh length count
   `SHA_ASSERT_NXT(a_last_word_rearms, rsp_valid && !rsp_stall && rsp_last_word,
                   (state_ff == ST_IDLE) && (total_ff == 61'd0) && (pos_ff == 6'd0))

endmodule

`default_nettype wire

// ===== sim/sha256_message_hasher_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_hasher_core_tb
// feeds byte-serial messages into the hasher and checks every digest word
// against a sha-256 predictor kept in a small scoreboard class; runs directed
// corner messages, then random messages under several idle and stall mixes
// ----------------------------------------------------------------------------

module sha256_message_hasher_core_tb;

   // generous ceiling on run length, in clock cycles
   localparam int CYCLE_LIMIT   = 400000;
   // cycles to wait after the last digest word for any stray response
   localparam int DRAIN_CYCLES  = 250;
   // random request budget per idle/stall phase
   localparam int PHASE_ITEMS   = 111;

   // one expected digest word
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_entry_type;

   // sha-256 predictor plus the queue of digest words it has produced
   class digest_scoreboard_type;
      logic [31:0]      round_k [64];
      logic [31:0]      start_hash [8];
      logic [31:0]      hash_state [8];
      logic [7:0]       block_bytes [64];
      logic [5:0]       block_fill;
      logic [60:0]      byte_count;
      digest_entry_type expected_digest_words [$];
      int               mismatches;
      int               words_checked;
      int               messages_hashed;

      function new();
         round_k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
         start_hash = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
         mismatches      = 0;
         words_checked   = 0;
         messages_hashed = 0;
         restart_message();
      endfunction

      function void restart_message();
         hash_state = start_hash;
         block_fill = '0;
         byte_count = '0;
      endfunction

      function logic [31:0] rotr(input logic [31:0] x, input int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress_block();
         logic [31:0] w [64];
         logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
         int t;
         for (t = 0; t < 16; t++)
            w[t] = {block_bytes[4*t], block_bytes[4*t+1],
                    block_bytes[4*t+2], block_bytes[4*t+3]};
         for (t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
         end
         a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
         e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
         for (t = 0; t < 64; t++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + round_k[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
         end
         hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
         hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
      endfunction

      function void absorb(input logic [7:0] value);
         block_bytes[block_fill] = value;
         if (block_fill == 6'd63)
            compress_block();
         block_fill = block_fill + 6'd1;
      endfunction

      // one accepted request: absorb its byte, and on end of message pad and queue digest
      function void note_request(input logic [7:0] data, input logic present,
                                 input logic eom);
         logic [63:0]      bit_len;
         digest_entry_type entry;
         int i;
         if (present) begin
            absorb(data);
            byte_count = byte_count + 61'd1;
         end
         if (!eom)
            return;
         bit_len = {byte_count, 3'b000};
         absorb(8'h80);
         while (block_fill != 6'd56)
            absorb(8'h00);
         for (i = 7; i >= 0; i--)
            absorb(bit_len[8*i +: 8]);
         for (i = 0; i < 8; i++) begin
            entry.word  = hash_state[i];
            entry.index = i[2:0];
            entry.last  = (i == 7);
            expected_digest_words = {expected_digest_words, entry};
         end
         messages_hashed++;
         restart_message();
      endfunction

      function void check_response(input logic [31:0] word, input logic [2:0] index,
                                   input logic last);
         digest_entry_type want;
         if (expected_digest_words.size() == 0) begin
            $error("unexpected response: digest_word %h word_index %0d", word, index);
            mismatches++;
            return;
         end
         want = expected_digest_words.pop_front();
         words_checked++;
         if (word !== want.word) begin
            $error("digest_word: expected %h, actual %h", want.word, word);
            mismatches++;
         end
         if (index !== want.index) begin
            $error("word_index: expected %0d, actual %0d", want.index, index);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last_word: expected %0b, actual %0b", want.last, last);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_digest_words.size();
      endfunction
   endclass

   // clock, reset and block ports
   logic        clock;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte      = 8'h00;
   logic        req_byte_present   = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   // idle mix of the current phase, in percent of cycles
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int cycle_count    = 0;
   int longest_msg    = 0;
   digest_scoreboard_type sb;

   sha256_message_hasher_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sha256_message_hasher_core_tb: FAIL");
         $finish;
      end
   end

   // response side: check on each accepted word, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_digest_word, rsp_word_index, rsp_last_word);
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // drive one request and hold it until accepted; valid stays high on return
   // so that back-to-back requests never toggle it within a time step
   task automatic send_request(input logic [7:0] data, input logic present,
                               input logic eom);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= data;
      req_byte_present   <= present;
      req_end_of_message <= eom;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_request(data, present, eom);
   endtask

   // hold off the request side until every digest word has come back
   task automatic wait_for_digests();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // one message of len bytes, with scattered empty requests as noise;
   // the end flag rides on the last byte or comes as a byteless request
   task automatic send_message(input int len, input bit end_on_byte, output int counted);
      int i;
      counted = 0;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) begin
            send_request(8'($urandom), 1'b0, 1'b0);
            counted++;
         end
         send_request(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
         counted++;
      end
      if (!end_on_byte || len == 0) begin
         send_request(8'($urandom), 1'b0, 1'b1);
         counted++;
      end
      if (len > longest_msg)
         longest_msg = len;
   endtask

   // mostly short messages, a share near the one/two block padding edge,
   // and a few spanning two or more blocks
   function automatic int pick_length();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70)
         return $urandom_range(0, 12);
      else if (sel < 90)
         return $urandom_range(52, 66);
      else
         return $urandom_range(100, 135);
   endfunction

   task automatic run_phase(input int idle_pct, input int stall_pct);
      int sent;
      int n;
      int len;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         len = pick_length();
         // keep the phase close to its request budget
         if (len > PHASE_ITEMS - sent)
            len = PHASE_ITEMS - sent;
         send_message(len, 1'($urandom_range(1)), n);
         sent += n;
      end
      // sender pause: let the hasher drain completely between phases
      wait_for_digests();
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, no idling
      // empty message straight out of reset
      send_request(8'h00, 1'b0, 1'b1);
      // two empty messages back to back
      send_request(8'hff, 1'b0, 1'b1);
      // single byte extremes with the end flag on the byte
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'hff, 1'b1, 1'b1);
      // "abc" with an empty request inside and a byteless end
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h5a, 1'b0, 1'b0);
      send_request(8'h63, 1'b1, 1'b0);
      send_request(8'ha5, 1'b0, 1'b1);
      // empty requests alone change nothing
      send_request(8'hff, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b0);
      send_request(8'h3c, 1'b0, 1'b1);
      // alternating bit patterns
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'h7f, 1'b1, 1'b0);
      send_request(8'h55, 1'b1, 1'b0);
      send_request(8'haa, 1'b1, 1'b1);
      wait_for_digests();

      // random part under each idle/stall mix
      run_phase(0, 0);
      run_phase(87, 0);
      run_phase(0, 87);
      run_phase(19, 19);

      // anything arriving now is unexpected
      rsp_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("hashed %0d messages up to %0d bytes long, %0d digest words checked",
               sb.messages_hashed, longest_msg, sb.words_checked);
      $display("covered empty messages, byteless ends, noise requests and padding edges");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("sha256_message_hasher_core_tb: PASS");
      end else begin
         $display("sha256_message_hasher_core_tb: FAIL");
      end
      $finish;
   end

endmodule
